[src/urfr_pkg.sv]
// Package for the UART reply frame receiver: command and status codes,
// frame constants and the bytewise CRC-8 update.
// No dependencies; used by urfr_core and uart_reply_frame_receiver.
`default_nettype none

package urfr_pkg;

    // Command carried in tuser of the input channel.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // Status carried in tuser of the result channel.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TIMEOUT      = 2'd1,
        ST_CRC_ERR      = 2'd2,
        ST_REG_MISMATCH = 2'd3
    } t_status;

    localparam int unsigned TIMEOUT_W = 10;
    localparam int unsigned REG_W     = 7;
    localparam int unsigned COUNT_W   = 3;

    localparam logic [7:0]           CRC_POLY      = 8'h07;
    localparam logic [7:0]           SYNC_BYTE     = 8'h05;
    localparam logic [7:0]           MASTER_ADDR   = 8'hFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd5;

    // Frame byte positions.
    localparam logic [COUNT_W-1:0] POS_SYNC      = 3'd0;
    localparam logic [COUNT_W-1:0] POS_ADDR      = 3'd1;
    localparam logic [COUNT_W-1:0] POS_REG       = 3'd2;
    localparam logic [COUNT_W-1:0] POS_VAL_FIRST = 3'd3;
    localparam logic [COUNT_W-1:0] POS_CRC       = 3'd7;

    // One byte of the LSB-first CRC-8, eight shift steps unrolled.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[7] ^ data[k];
            crc = {crc[6:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[src/urfr_core.sv]
// Frame matching core: holds the reply state and works one item per step,
// producing at most one result combinationally from the stepped item.
// Depends on urfr_pkg.
`default_nettype none

module urfr_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire urfr_pkg::t_cmd                 i_cmd,
    input  wire logic [urfr_pkg::REG_W-1:0]     i_reg_number,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic [urfr_pkg::TIMEOUT_W-1:0] i_timeout_ticks,
    output logic                                o_res_valid,
    output urfr_pkg::t_status                   o_res_status,
    output logic [7:0]                          o_res_reply_reg,
    output logic [31:0]                         o_res_value
);

    logic                            r_busy,        n_busy;
    logic [urfr_pkg::COUNT_W-1:0]    r_byte_count,  n_byte_count;
    logic [7:0]                      r_crc,         n_crc;
    logic [31:0]                     r_value,       n_value;
    logic [7:0]                      r_got_reg,     n_got_reg;
    logic [urfr_pkg::REG_W-1:0]      r_want_reg,    n_want_reg;
    logic [urfr_pkg::TIMEOUT_W-1:0]  r_tick_count,  n_tick_count;
    logic [urfr_pkg::TIMEOUT_W-1:0]  tick_inc;
    logic [7:0]                      crc_upd;
    logic [7:0]                      crc_fresh;

    assign tick_inc  = r_tick_count + 1'b1;
    assign crc_upd   = urfr_pkg::crc_byte(r_crc, i_rx_byte);
    assign crc_fresh = urfr_pkg::crc_byte(8'h00, i_rx_byte);

    // Next state and result for the item being stepped.
    always_comb begin
        n_busy          = r_busy;
        n_byte_count    = r_byte_count;
        n_crc           = r_crc;
        n_value         = r_value;
        n_got_reg       = r_got_reg;
        n_want_reg      = r_want_reg;
        n_tick_count    = r_tick_count;
        o_res_valid     = 1'b0;
        o_res_status    = urfr_pkg::ST_OK;
        o_res_reply_reg = 8'h00;
        o_res_value     = 32'h0;

        if (i_step) begin
            case (i_cmd)
                urfr_pkg::CMD_START: begin
                    n_busy       = 1'b1;
                    n_want_reg   = i_reg_number;
                    n_tick_count = '0;
                    n_byte_count = urfr_pkg::POS_SYNC;
                    n_crc        = 8'h00;
                    n_value      = 32'h0;
                    n_got_reg    = 8'h00;
                end
                urfr_pkg::CMD_TICK: begin
                    if (r_busy) begin
                        n_tick_count = tick_inc;
                        // A wrapped count also counts as expired.
                        if ((tick_inc >= i_timeout_ticks) || (tick_inc == '0)) begin
                            n_busy       = 1'b0;
                            o_res_valid  = 1'b1;
                            o_res_status = urfr_pkg::ST_TIMEOUT;
                        end
                    end
                end
                urfr_pkg::CMD_BYTE: begin
                    if (r_busy) begin
                        if (r_byte_count == urfr_pkg::POS_SYNC) begin
                            if (i_rx_byte == urfr_pkg::SYNC_BYTE) begin
                                n_crc        = crc_fresh;
                                n_byte_count = urfr_pkg::POS_ADDR;
                            end
                        end else if (r_byte_count == urfr_pkg::POS_ADDR) begin
                            if (i_rx_byte == urfr_pkg::MASTER_ADDR) begin
                                n_crc        = crc_upd;
                                n_byte_count = urfr_pkg::POS_REG;
                            end else if (i_rx_byte == urfr_pkg::SYNC_BYTE) begin
                                // Restart the match on this sync byte.
                                n_crc        = crc_fresh;
                                n_byte_count = urfr_pkg::POS_ADDR;
                            end else begin
                                n_byte_count = urfr_pkg::POS_SYNC;
                                n_crc        = 8'h00;
                                n_value      = 32'h0;
                                n_got_reg    = 8'h00;
                            end
                        end else if (r_byte_count == urfr_pkg::POS_REG) begin
                            n_got_reg    = i_rx_byte;
                            n_crc        = crc_upd;
                            n_byte_count = urfr_pkg::POS_VAL_FIRST;
                        end else if (r_byte_count != urfr_pkg::POS_CRC) begin
                            n_value      = {r_value[23:0], i_rx_byte};
                            n_crc        = crc_upd;
                            n_byte_count = r_byte_count + 1'b1;
                        end else begin
                            // Final byte: check CRC first, then the register.
                            n_busy          = 1'b0;
                            o_res_valid     = 1'b1;
                            o_res_reply_reg = r_got_reg;
                            if (r_crc != i_rx_byte) begin
                                o_res_status = urfr_pkg::ST_CRC_ERR;
                            end else if (r_got_reg != {1'b0, r_want_reg}) begin
                                o_res_status = urfr_pkg::ST_REG_MISMATCH;
                            end else begin
                                o_res_status = urfr_pkg::ST_OK;
                                o_res_value  = r_value;
                            end
                            n_byte_count = urfr_pkg::POS_SYNC;
                            n_crc        = 8'h00;
                            n_value      = 32'h0;
                            n_got_reg    = 8'h00;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_byte_count <= urfr_pkg::POS_SYNC;
            r_crc        <= 8'h00;
            r_value      <= 32'h0;
            r_got_reg    <= 8'h00;
            r_want_reg   <= '0;
            r_tick_count <= '0;
        end else begin
            r_busy       <= n_busy;
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_value      <= n_value;
            r_got_reg    <= n_got_reg;
            r_want_reg   <= n_want_reg;
            r_tick_count <= n_tick_count;
        end
    end

endmodule

`default_nettype wire

[src/uart_reply_frame_receiver.sv]
// Top level of the UART reply frame receiver: input register, result
// register and timeout register around urfr_core.
// Depends on urfr_pkg and urfr_core.
//
// Usage: each transfer on the slave stream is one item: tuser holds the
// command (start a read, received byte, time tick), tdata the register number
// and the received byte. A start arms the block; bytes are matched against
// the reply frame (sync 0x05, master address 0xFF, register, four value
// bytes, CRC-8). After the eighth byte, or when the tick count reaches the
// timeout register, one result transfer appears on the master stream with
// the status in tuser and the reply register and big-endian value in tdata.
// The result is registered: the item passes from the input register through the state
// logic into the result register.
// One item is taken every cycle while the result register is free or being
// emptied; the state update is a single pass of logic per item.
// A stalled master side holds the result; the input register then fills and
// s_axis_tready drops until the result is taken. Reset clears both registers and
// the frame state and loads the timeout register with 5 ticks. The timeout is to be
// written through i_cfg_wr_en by the user only while idle; the block does not enforce it.
`default_nettype none

module uart_reply_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: timeout in ticks.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [9:0]  i_cfg_wr_data,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [6:0] reg_number, [14:7] rx_byte, [15] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] reply_reg, [39:8] value
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    logic                            r_in_valid;
    urfr_pkg::t_cmd                  r_in_cmd;
    logic [urfr_pkg::REG_W-1:0]      r_in_reg;
    logic [7:0]                      r_in_byte;
    logic [urfr_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic                            r_out_valid;
    urfr_pkg::t_status               r_out_status;
    logic [7:0]                      r_out_reply_reg;
    logic [31:0]                     r_out_value;

    logic                            advance;
    logic                            in_xfer;
    logic                            res_valid;
    urfr_pkg::t_status               res_status;
    logic [7:0]                      res_reply_reg;
    logic [31:0]                     res_value;

    // The held item moves on whenever the result register has room.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= urfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd  <= urfr_pkg::t_cmd'(s_axis_tuser);
            r_in_reg  <= s_axis_tdata[6:0];
            r_in_byte <= s_axis_tdata[14:7];
        end
    end

    urfr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_cmd           (r_in_cmd),
        .i_reg_number    (r_in_reg),
        .i_rx_byte       (r_in_byte),
        .i_timeout_ticks (r_timeout),
        .o_res_valid     (res_valid),
        .o_res_status    (res_status),
        .o_res_reply_reg (res_reply_reg),
        .o_res_value     (res_value)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_status    <= res_status;
            r_out_reply_reg <= res_reply_reg;
            r_out_value     <= res_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_reply_reg};
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

[verif/uart_reply_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uart_reply_frame_receiver: directed frames, timeout
// settings, a long back-pressure stall and random reply traffic against a local predictor.
// Depends on urfr_pkg and the uart_reply_frame_receiver RTL.

module uart_reply_frame_receiver_tb;

    // Command code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned HALF_PERIOD     = 5;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    // The directed tests send about 1100 items; random traffic tops that up.
    localparam int unsigned RANDOM_ITEMS    = 200;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned NUM_PHASES      = 5;

    // One expected result transfer.
    typedef struct packed {
        urfr_pkg::t_status status;
        logic [7:0]        reply_reg;
        logic [31:0]       value;
    } t_reply;

    // Stimulus and DUT connections.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [9:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [6:0] reg_number, [14:7] rx_byte, [15] zero
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [7:0] reply_reg, [39:8] value
    logic [1:0]  m_axis_tuser;          // [1:0] status

    // Predictor state: a copy of the receiver's frame tracking.
    logic [urfr_pkg::TIMEOUT_W-1:0] timeout_setting = urfr_pkg::TIMEOUT_RESET;
    logic                           armed           = 1'b0;
    logic [urfr_pkg::COUNT_W-1:0]   frame_pos       = urfr_pkg::POS_SYNC;
    logic [7:0]                     frame_crc       = '0;
    logic [31:0]                    frame_value     = '0;
    logic [7:0]                     frame_reg       = '0;
    logic [urfr_pkg::REG_W-1:0]     asked_reg       = '0;
    logic [urfr_pkg::TIMEOUT_W-1:0] ticks_seen      = '0;
    t_reply                         pending_replies[$];

    // Run control and statistics.
    bit          sender_gaps   = 1'b1;
    bit          hold_off_req  = 1'b0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned items_total   = 0;
    int unsigned items_acted   = 0;
    int unsigned results_seen  = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    uart_reply_frame_receiver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: a run that hangs or loses a result ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_replies.size());
            $display("FAIL");
            $finish;
        end
    end

    // CRC-8, polynomial 0x07, data taken least significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        int         i;
        acc = crc;
        for (i = 0; i < 8; i++) begin
            if (acc[7] != data[i]) begin
                acc = {acc[6:0], 1'b0} ^ urfr_pkg::CRC_POLY;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    function automatic void forget_frame();
        frame_pos   = urfr_pkg::POS_SYNC;
        frame_crc   = '0;
        frame_value = '0;
        frame_reg   = '0;
    endfunction

    // Advances the predicted receiver by one accepted item and queues any result.
    task automatic advance_frame_state(input logic [1:0] cmd,
                                       input logic [urfr_pkg::REG_W-1:0] reg_no,
                                       input logic [7:0] rx, output bit acted);
        t_reply r;
        r     = '0;
        acted = 1'b1;
        if (cmd == urfr_pkg::CMD_START) begin
            armed      = 1'b1;
            asked_reg  = reg_no;
            ticks_seen = '0;
            forget_frame();
        end else if (!armed || cmd == CMD_UNUSED) begin
            acted = 1'b0;
        end else if (cmd == urfr_pkg::CMD_TICK) begin
            ticks_seen = ticks_seen + 1'b1;
            if (ticks_seen >= timeout_setting || ticks_seen == '0) begin
                armed    = 1'b0;
                r.status = urfr_pkg::ST_TIMEOUT;
                pending_replies.push_back(r);
            end
        end else begin
            case (frame_pos)
                urfr_pkg::POS_SYNC: begin
                    if (rx == urfr_pkg::SYNC_BYTE) begin
                        frame_crc = crc8_update(8'h00, rx);
                        frame_pos = urfr_pkg::POS_ADDR;
                    end
                end
                urfr_pkg::POS_ADDR: begin
                    if (rx == urfr_pkg::MASTER_ADDR) begin
                        frame_crc = crc8_update(frame_crc, rx);
                        frame_pos = urfr_pkg::POS_REG;
                    end else if (rx == urfr_pkg::SYNC_BYTE) begin
                        // A second sync byte starts the match over from itself.
                        frame_crc = crc8_update(8'h00, rx);
                        frame_pos = urfr_pkg::POS_ADDR;
                    end else begin
                        forget_frame();
                    end
                end
                urfr_pkg::POS_REG: begin
                    frame_reg = rx;
                    frame_crc = crc8_update(frame_crc, rx);
                    frame_pos = urfr_pkg::POS_VAL_FIRST;
                end
                default: begin
                    if (frame_pos != urfr_pkg::POS_CRC) begin
                        frame_value = {frame_value[23:0], rx};
                        frame_crc   = crc8_update(frame_crc, rx);
                        frame_pos   = frame_pos + 1'b1;
                    end else begin
                        // The CRC is judged before the echoed register number.
                        armed       = 1'b0;
                        r.reply_reg = frame_reg;
                        if (frame_crc != rx) begin
                            r.status = urfr_pkg::ST_CRC_ERR;
                        end else if (frame_reg != {1'b0, asked_reg}) begin
                            r.status = urfr_pkg::ST_REG_MISMATCH;
                        end else begin
                            r.status = urfr_pkg::ST_OK;
                            r.value  = frame_value;
                        end
                        pending_replies.push_back(r);
                        forget_frame();
                    end
                end
            endcase
        end
    endtask

    // Sender idle time: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!sender_gaps || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one item, waits for its transfer and feeds it to the predictor.
    // Called and returns at a falling edge.
    task automatic send_item(input logic [1:0] cmd, input logic [urfr_pkg::REG_W-1:0] reg_no,
                             input logic [7:0] rx);
        bit          acted;
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, rx, reg_no};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        advance_frame_state(cmd, reg_no, rx, acted);
        items_total++;
        if (acted) begin
            items_acted++;
        end
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_start(input logic [urfr_pkg::REG_W-1:0] reg_no);
        send_item(urfr_pkg::CMD_START, reg_no, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(urfr_pkg::CMD_BYTE, urfr_pkg::REG_W'($urandom), rx);
    endtask

    task automatic send_tick();
        send_item(urfr_pkg::CMD_TICK, urfr_pkg::REG_W'($urandom), 8'($urandom));
    endtask

    // Sends the first keep bytes of a reply frame, with ticks mixed in at random.
    task automatic send_frame(input logic [7:0] reg_byte, input logic [31:0] value,
                              input logic [7:0] crc_flip, input int unsigned tick_pct,
                              input int unsigned keep);
        logic [7:0]  frame_bytes[8];
        logic [7:0]  crc;
        int unsigned k;
        frame_bytes[0] = urfr_pkg::SYNC_BYTE;
        frame_bytes[1] = urfr_pkg::MASTER_ADDR;
        frame_bytes[2] = reg_byte;
        frame_bytes[3] = value[31:24];
        frame_bytes[4] = value[23:16];
        frame_bytes[5] = value[15:8];
        frame_bytes[6] = value[7:0];
        crc = 8'h00;
        for (k = 0; k < 7; k++) begin
            crc = crc8_update(crc, frame_bytes[k]);
        end
        frame_bytes[7] = crc ^ crc_flip;
        for (k = 0; k < keep; k++) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_tick();
            end
            send_byte(frame_bytes[k]);
        end
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write; only issued once the block has drained.
    task automatic write_timeout(input logic [urfr_pkg::TIMEOUT_W-1:0] ticks);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(negedge i_clk);
        i_cfg_wr_en     <= 1'b0;
        timeout_setting  = ticks;
    endtask

    task automatic report_mismatch(input string what);
        $display("Mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Result side: random stalls in stretches, plus the long hold-off on request.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned held;
        int unsigned roll;
        bit          steady;
        stall_left = 0;
        steady     = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                steady = ~steady;
            end
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
                    @(negedge i_clk);
                end
                hold_off_req   = 1'b0;
                stall_left     = 0;
                m_axis_tready <= 1'b1;
            end else if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) begin
                        stall_left = 0;
                    end else if (roll < 93) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (roll < 99) begin
                        stall_left = $urandom_range(4, 15);
                    end else begin
                        stall_left = $urandom_range(30, 80);
                    end
                end
            end
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_reply oldest;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result status %0d with nothing expected",
                                          m_axis_tuser));
            end else begin
                oldest = pending_replies.pop_front();
                results_seen++;
                status_seen[oldest.status]++;
                if (m_axis_tuser !== oldest.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser, oldest.status));
                end
                if (m_axis_tdata[7:0] !== oldest.reply_reg) begin
                    report_mismatch($sformatf("reply_reg %h, expected %h",
                                              m_axis_tdata[7:0], oldest.reply_reg));
                end
                if (m_axis_tdata[39:8] !== oldest.value) begin
                    report_mismatch($sformatf("value %h, expected %h",
                                              m_axis_tdata[39:8], oldest.value));
                end
            end
        end
    end

    // Bytes, ticks and the unused code are all dropped while no read is pending.
    task automatic test_idle_and_unused();
        send_byte(urfr_pkg::SYNC_BYTE);
        send_tick();
        send_item(CMD_UNUSED, '1, 8'hFF);
    endtask

    // The reset timeout of five ticks applies before any register write.
    task automatic test_default_timeout();
        int unsigned k;
        send_start(7'h7F);
        for (k = 0; k < 5; k++) begin
            send_tick();
        end
    endtask

    // Repeated sync byte, an ignored code mid-read and an all-ones value.
    task automatic test_resync_and_good_frame();
        send_start(7'h00);
        send_item(CMD_UNUSED, '0, 8'h00);
        send_byte(urfr_pkg::SYNC_BYTE);
        send_frame(8'h00, 32'hFFFF_FFFF, 8'h00, 0, 8);
    endtask

    // A restart mid-frame, then a reply with both a bad CRC and a foreign register
    // (top bit set): the CRC error wins.
    task automatic test_crc_checked_first();
        send_start(7'h55);
        send_byte(urfr_pkg::SYNC_BYTE);
        send_start(7'h2A);
        send_frame(8'hAA, 32'h0000_0000, 8'h01, 0, 8);
    endtask

    // Timeout register at zero: the first tick ends the read.
    task automatic test_timeout_register_zero();
        wait_drained();
        write_timeout('0);
        send_start(7'h11);
        send_tick();
    endtask

    // Largest timeout: 1022 ticks pass quietly, the next one times out.
    task automatic test_longest_timeout();
        int unsigned k;
        wait_drained();
        write_timeout('1);
        sender_gaps = 1'b0;
        send_start(7'h33);
        for (k = 0; k < 1023; k++) begin
            send_tick();
        end
        sender_gaps = 1'b1;
    endtask

    // The result side holds off while results keep coming, so the input stalls.
    task automatic test_back_pressure();
        int unsigned k;
        wait_drained();
        write_timeout(10'd1);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 12; k++) begin
            send_start(urfr_pkg::REG_W'($urandom));
            send_tick();
        end
        send_start(7'h42);
        send_frame(8'h42, $urandom, 8'h00, 0, 8);
        sender_gaps = 1'b1;
    endtask

    // Random read sequences: mostly plausible replies with random content,
    // some echoes, corruptions, truncations and plain noise.
    task automatic random_read(input int unsigned tick_pct);
        logic [urfr_pkg::REG_W-1:0] want;
        logic [7:0]                 reg_byte;
        logic [7:0]                 crc_flip;
        logic [7:0]                 echo_crc;
        logic [7:0]                 node;
        logic [31:0]                value;
        int unsigned                keep;
        int unsigned                k;
        sender_gaps = ($urandom_range(0, 3) != 0);
        want        = urfr_pkg::REG_W'($urandom);
        if ($urandom_range(0, 99) < 6) begin
            for (k = $urandom_range(1, 5); k != 0; k--) begin
                send_item(2'($urandom), urfr_pkg::REG_W'($urandom), 8'($urandom));
            end
        end else begin
            send_start(want);
            if ($urandom_range(0, 4) == 0) begin
                for (k = $urandom_range(1, 3); k != 0; k--) begin
                    send_byte(8'($urandom));
                end
            end
            // Echo of our own read request on the shared wire.
            if ($urandom_range(0, 2) == 0) begin
                node     = 8'($urandom_range(0, 3));
                echo_crc = crc8_update(crc8_update(crc8_update(8'h00, urfr_pkg::SYNC_BYTE),
                                                   node), {1'b0, want});
                send_byte(urfr_pkg::SYNC_BYTE);
                send_byte(node);
                send_byte({1'b0, want});
                send_byte(echo_crc);
            end
            reg_byte = ($urandom_range(0, 99) < 80) ? {1'b0, want} : 8'($urandom);
            crc_flip = ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
            keep     = ($urandom_range(0, 99) < 85) ? 8 : $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_frame(reg_byte, value, crc_flip, tick_pct, keep);
            if (keep < 8 && $urandom_range(0, 1) == 0) begin
                for (k = $urandom_range(1, 4); k != 0; k--) begin
                    send_tick();
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [urfr_pkg::TIMEOUT_W-1:0] phase_timeout[NUM_PHASES] =
            '{10'd6, 10'd1, 10'd25, 10'd1023, 10'd3};
        int unsigned                    phase_tick_pct[NUM_PHASES] = '{8, 3, 15, 20, 5};
        int unsigned                    phase;
        int unsigned                    goal;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            write_timeout(phase_timeout[phase]);
            goal = items_total + RANDOM_ITEMS / NUM_PHASES;
            while (items_total < goal) begin
                random_read(phase_tick_pct[phase]);
            end
        end
        sender_gaps = 1'b1;
    endtask

    // Test sequence.
    initial begin : run_tests
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_idle_and_unused();
        test_default_timeout();
        test_resync_and_good_frame();
        test_crc_checked_first();
        test_timeout_register_zero();
        test_longest_timeout();
        test_back_pressure();
        test_random_traffic();
        wait_drained();
        $display("Sent %0d items (%0d acted on) over timeouts 0 to 1023, with stalls.",
                 items_total, items_acted);
        $display("Checked %0d results: ok %0d, timeout %0d, crc %0d, wrong register %0d.",
                 results_seen, status_seen[urfr_pkg::ST_OK],
                 status_seen[urfr_pkg::ST_TIMEOUT], status_seen[urfr_pkg::ST_CRC_ERR],
                 status_seen[urfr_pkg::ST_REG_MISMATCH]);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/urfr_pkg.sv
src/urfr_core.sv
src/uart_reply_frame_receiver.sv
verif/uart_reply_frame_receiver_tb.sv
